// ===== hw/rtl/lmts_pkg.sv =====
// ----------------------------------------------------------------------------
// lmts_pkg
// shared types, constants and band tables of the tuner search sequencer
// ----------------------------------------------------------------------------
package lmts_pkg;

    localparam int NUM_BANDS      = 6;
    localparam int NUM_SWEEP_ROWS = 72;
    localparam int HELD_BANDS     = 6;
    localparam int HELD_ROWS      = 72;
    localparam int ROW_LIMIT      = (NUM_SWEEP_ROWS < HELD_ROWS) ? NUM_SWEEP_ROWS : HELD_ROWS;
    localparam int BAND_COUNT     = (NUM_BANDS < HELD_BANDS) ? NUM_BANDS : HELD_BANDS;

    localparam logic [15:0] THR_FULL   = 16'd150;
    localparam logic [15:0] THR_QUICK  = 16'd120;
    localparam logic [15:0] VSWR_WORST = 16'hFFFF;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_COARSE1 = 3'd1;
    localparam logic [2:0] PH_COARSE2 = 3'd2;
    localparam logic [2:0] PH_MID1    = 3'd3;
    localparam logic [2:0] PH_MID2    = 3'd4;
    localparam logic [2:0] PH_FINE1   = 3'd5;
    localparam logic [2:0] PH_FINE2   = 3'd6;
    localparam logic [2:0] PH_FINISH  = 3'd7;

    localparam logic [1:0] REG_FREQ  = 2'd0;
    localparam logic [1:0] REG_QUICK = 2'd1;
    localparam logic [1:0] REG_TPS   = 2'd2;
    localparam logic [1:0] REG_DELAY = 2'd3;

    typedef struct packed {
        logic [7:0] fmax;
        logic [7:0] start;
        logic [7:0] nrows;
        logic [7:0] lmax;
        logic [7:0] cmax;
        logic [7:0] s1b;
        logic [7:0] midr;
        logic [7:0] mids;
        logic [7:0] finer;
    } t_band;

    typedef struct packed {
        logic [7:0] high;
        logic [7:0] incr;
        logic [7:0] fx0;
        logic [7:0] fx1;
        logic [7:0] fx2;
    } t_group;

    typedef struct packed {
        logic [7:0] freq_mhz;
        logic       quick_tune_enable;
        logic [7:0] ticks_per_step;
        logic [7:0] start_delay_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] vswr;
        logic [7:0]  hw_l;
        logic [7:0]  hw_c;
        logic        hw_z;
    } t_item;

    typedef struct packed {
        logic       drive;
        logic [7:0] l;
        logic [7:0] c;
        logic       z;
        logic       rep;
        logic       ok;
        logic       active;
        logic [2:0] phase;
    } t_result;

    function automatic t_band band_row_f(input logic [2:0] r);
        t_band b;
        case (r)
            3'd1:    b = '{8'd3, 8'd12, 8'd12, 8'd255, 8'd255, 8'd24, 8'd32, 8'd4, 8'd8};
            3'd2:    b = '{8'd7, 8'd24, 8'd12, 8'd210, 8'd210, 8'd12, 8'd24, 8'd4, 8'd8};
            3'd3:    b = '{8'd14, 8'd36, 8'd12, 8'd100, 8'd100, 8'd6, 8'd12, 8'd2, 8'd8};
            3'd4:    b = '{8'd29, 8'd48, 8'd12, 8'd60, 8'd60, 8'd3, 8'd8, 8'd1, 8'd8};
            3'd5:    b = '{8'd64, 8'd60, 8'd12, 8'd30, 8'd30, 8'd2, 8'd8, 8'd1, 8'd8};
            default: b = '{8'd1, 8'd0, 8'd12, 8'd255, 8'd255, 8'd24, 8'd32, 8'd4, 8'd8};
        endcase
        return b;
    endfunction

    function automatic t_group group_f(input logic [2:0] g);
        t_group t;
        case (g)
            3'd1:    t = '{8'd255, 8'd24, 8'd0, 8'd36, 8'd72};
            3'd2:    t = '{8'd210, 8'd20, 8'd0, 8'd18, 8'd36};
            3'd3:    t = '{8'd100, 8'd10, 8'd0, 8'd18, 8'd36};
            3'd4:    t = '{8'd55, 8'd5, 8'd0, 8'd8, 8'd16};
            3'd5:    t = '{8'd20, 8'd2, 8'd0, 8'd3, 8'd6};
            default: t = '{8'd255, 8'd24, 8'd0, 8'd48, 8'd96};
        endcase
        return t;
    endfunction

    // v - r clamped to 0..hi, or v + r clamped to lo..hi
    function automatic logic [7:0] clamp_sub(input logic [7:0] v, input logic [7:0] r,
                                             input logic [7:0] hi);
        logic [8:0] d;
        d = {1'b0, v} - {1'b0, r};
        if (d[8]) return 8'd0;
        if (d[7:0] > hi) return hi;
        return d[7:0];
    endfunction

    function automatic logic [7:0] clamp_add(input logic [7:0] v, input logic [7:0] r,
                                             input logic [7:0] lo, input logic [7:0] hi);
        logic [8:0] s;
        s = {1'b0, v} + {1'b0, r};
        if (s < {1'b0, lo}) return lo;
        if (s > {1'b0, hi}) return hi;
        return s[7:0];
    endfunction

endpackage

// ===== hw/rtl/lmts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lmts_cfg_regs
// apb register bank of the tuner search sequencer
// ----------------------------------------------------------------------------
module lmts_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lmts_pkg::t_cfg     o_cfg
);
    lmts_pkg::t_cfg r_cfg;
    logic [1:0]     w_idx;

    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{8'd0, 1'b0, 8'd2, 8'd20};
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                lmts_pkg::REG_FREQ:  r_cfg.freq_mhz          <= pwdata[7:0];
                lmts_pkg::REG_QUICK: r_cfg.quick_tune_enable <= pwdata[0];
                lmts_pkg::REG_TPS:   r_cfg.ticks_per_step    <= pwdata[7:0];
                lmts_pkg::REG_DELAY: r_cfg.start_delay_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            lmts_pkg::REG_FREQ:  prdata = {24'd0, r_cfg.freq_mhz};
            lmts_pkg::REG_QUICK: prdata = {31'd0, r_cfg.quick_tune_enable};
            lmts_pkg::REG_TPS:   prdata = {24'd0, r_cfg.ticks_per_step};
            lmts_pkg::REG_DELAY: prdata = {24'd0, r_cfg.start_delay_ticks};
            default:             prdata = 32'd0;
        endcase
    end
endmodule

// ===== hw/rtl/lmts_core.sv =====
// ----------------------------------------------------------------------------
// lmts_core
// search state and next-state logic, one transaction per enable
// ----------------------------------------------------------------------------
module lmts_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  lmts_pkg::t_cfg      i_cfg,
    input  lmts_pkg::t_item     i_item,
    output lmts_pkg::t_result   o_res
);
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_div, n_div;
    logic        r_quick, n_quick, r_active, n_active;
    logic [2:0]  r_band, n_band;
    logic [3:0]  r_tri, n_tri;
    logic        r_shz, n_shz, r_sind, n_sind;
    logic [7:0]  r_slo, n_slo, r_shi, n_shi, r_sinc, n_sinc, r_sfx, n_sfx;
    logic [7:0]  r_cl, n_cl, r_cc, n_cc;
    logic        r_chz, n_chz;
    logic [7:0]  r_bl, n_bl, r_bc, n_bc;
    logic        r_bhz, n_bhz, r_bsi, n_bsi;
    logic [15:0] r_bv, n_bv;

    lmts_pkg::t_band  w_bandn, w_bando, w_band, w_cand;
    lmts_pkg::t_group w_grp;
    logic [2:0]  w_pick;
    logic [6:0]  w_absr, w_first, w_next;
    logic [2:0]  w_g;
    logic [3:0]  w_k;
    logic [3:0]  w_tri1;
    logic        w_row_ok, w_load, w_first_row, w_valid, w_drive, w_dbest, w_rep, w_ok;
    logic [7:0]  w_v, w_inc_v, w_range, w_sinc2, w_cl_pre, w_cc_pre;
    logic        w_sind_pre;
    logic [7:0]  w_bl_s, w_bc_s;
    logic        w_bhz_s, w_bsi_s;
    logic        w_setup;
    logic        w_fine;

    always_comb begin
        w_pick = 3'd0;
        w_cand = lmts_pkg::band_row_f(3'd0);
        for (int r = lmts_pkg::BAND_COUNT; r > 0; r--) begin
            w_cand = lmts_pkg::band_row_f(3'(r - 1));
            if (i_cfg.freq_mhz <= w_cand.fmax) w_pick = 3'(r - 1);
        end
    end

    assign w_bandn = lmts_pkg::band_row_f(w_pick);
    assign w_bando = lmts_pkg::band_row_f(r_band);
    assign w_tri1  = r_tri + 4'd1;

    always_comb begin
        w_first = (w_band.start >= 8'(lmts_pkg::ROW_LIMIT)) ? 7'(lmts_pkg::ROW_LIMIT - 1)
                                                            : w_band.start[6:0];
        w_next  = 7'({4'd0, w_tri1} + {1'b0, w_band.start});
    end

    always_comb begin
        n_phase = r_phase; n_div = r_div; n_quick = r_quick; n_active = r_active;
        n_band = r_band; n_tri = r_tri; n_shz = r_shz; n_sind = r_sind;
        n_slo = r_slo; n_shi = r_shi; n_sinc = r_sinc; n_sfx = r_sfx;
        n_cl = r_cl; n_cc = r_cc; n_chz = r_chz;
        n_bl = r_bl; n_bc = r_bc; n_bhz = r_bhz; n_bsi = r_bsi; n_bv = r_bv;
        w_band = w_bando; w_load = 1'b0; w_first_row = 1'b0; w_absr = 7'd0;
        w_valid = 1'b0; w_drive = 1'b0; w_dbest = 1'b0; w_rep = 1'b0; w_ok = 1'b0;
        w_setup = 1'b0; w_fine = 1'b0; w_row_ok = 1'b0;
        w_v = 8'd0; w_inc_v = 8'd0; w_range = 8'd0; w_sinc2 = 8'd0;
        w_bl_s = r_bl; w_bc_s = r_bc; w_bhz_s = r_bhz; w_bsi_s = r_bsi;
        w_cl_pre = r_cl; w_cc_pre = r_cc; w_sind_pre = r_sind;
        case (i_item.func)
            lmts_pkg::FUNC_START: begin
                n_band = w_pick;
                w_band = w_bandn;
                if (i_cfg.quick_tune_enable) begin
                    n_quick = 1'b1; n_phase = lmts_pkg::PH_FINE1;
                    n_shz = i_item.hw_z; n_sind = 1'b1; n_sinc = 8'd1; n_sfx = i_item.hw_c;
                    n_slo = lmts_pkg::clamp_sub(i_item.hw_l, w_band.finer, w_band.lmax);
                    n_shi = lmts_pkg::clamp_add(i_item.hw_l, w_band.finer, 8'd0, w_band.lmax);
                    n_chz = i_item.hw_z; n_cc = i_item.hw_c; n_cl = n_slo;
                end else begin
                    n_quick = 1'b0; n_phase = lmts_pkg::PH_COARSE1;
                    w_first_row = 1'b1;
                end
                n_div = i_cfg.start_delay_ticks; n_active = 1'b1; n_bv = lmts_pkg::VSWR_WORST;
                w_drive = 1'b1;
            end
            lmts_pkg::FUNC_CANCEL: begin
                n_active = 1'b0; n_phase = lmts_pkg::PH_IDLE;
            end
            lmts_pkg::FUNC_TICK: begin
                if (r_div > 8'd1) begin
                    n_div = r_div - 8'd1;
                end else begin
                    n_div = i_cfg.ticks_per_step;
                    n_phase = r_active ? r_phase : lmts_pkg::PH_IDLE;
                    if (n_phase != lmts_pkg::PH_IDLE && n_phase != lmts_pkg::PH_FINISH) begin
                        if (i_item.vswr < r_bv) begin
                            n_bv = i_item.vswr; w_bl_s = r_cl; w_bc_s = r_cc;
                            w_bhz_s = r_chz; w_bsi_s = r_sind;
                        end
                        w_v = r_sind ? r_cl : r_cc;
                        if (w_v != r_shi) begin
                            w_valid = 1'b1;
                            w_inc_v = lmts_pkg::clamp_add(w_v, r_sinc, r_slo, r_shi);
                            if (r_sind) w_cl_pre = w_inc_v; else w_cc_pre = w_inc_v;
                        end
                    end
                    n_bl = w_bl_s; n_bc = w_bc_s; n_bhz = w_bhz_s; n_bsi = w_bsi_s;
                    n_cl = w_cl_pre; n_cc = w_cc_pre;
                    case (n_phase)
                        lmts_pkg::PH_COARSE1: begin
                            if (!w_valid) begin
                                n_tri = w_tri1;
                                w_absr = w_next;
                                w_row_ok = ({4'd0, w_tri1} < w_band.nrows) &&
                                           (w_next < 7'(lmts_pkg::ROW_LIMIT));
                                if (w_row_ok) begin
                                    w_load = 1'b1;
                                end else begin
                                    n_phase = lmts_pkg::PH_COARSE2;
                                    n_shz = w_bhz_s; n_sind = !w_bsi_s;
                                    n_sinc = w_band.s1b; n_slo = 8'd0;
                                    n_shi = n_sind ? w_band.lmax : w_band.cmax;
                                    n_sfx = n_sind ? w_bc_s : w_bl_s;
                                    n_chz = n_shz;
                                    n_cl = n_sind ? 8'd0 : n_sfx;
                                    n_cc = n_sind ? n_sfx : 8'd0;
                                end
                            end
                        end
                        lmts_pkg::PH_COARSE2, lmts_pkg::PH_MID1, lmts_pkg::PH_MID2,
                        lmts_pkg::PH_FINE1: begin
                            if (!w_valid) begin
                                w_setup = 1'b1;
                                w_fine = (n_phase == lmts_pkg::PH_MID2) ||
                                         (n_phase == lmts_pkg::PH_FINE1);
                                n_phase = n_phase + 3'd1;
                            end
                        end
                        lmts_pkg::PH_FINE2: begin
                            if (!w_valid) begin
                                if (!r_quick || n_bv < lmts_pkg::THR_QUICK) begin
                                    w_ok = n_bv < (r_quick ? lmts_pkg::THR_QUICK
                                                           : lmts_pkg::THR_FULL);
                                    n_quick = 1'b0; n_phase = lmts_pkg::PH_FINISH;
                                    w_dbest = 1'b1; w_rep = 1'b1;
                                end else begin
                                    n_quick = 1'b0; n_bv = lmts_pkg::VSWR_WORST;
                                    n_phase = lmts_pkg::PH_COARSE1;
                                    w_first_row = 1'b1;
                                end
                            end
                        end
                        lmts_pkg::PH_FINISH: begin
                            n_phase = lmts_pkg::PH_IDLE; n_active = 1'b0;
                        end
                        default: ;
                    endcase
                    if (w_setup) begin
                        w_range = w_fine ? w_band.finer : w_band.midr;
                        w_sinc2 = w_fine ? 8'd1 : w_band.mids;
                        n_sind = !r_sind; n_sinc = w_sinc2; n_chz = r_shz;
                        if (n_sind) begin
                            n_sfx = w_bc_s;
                            n_slo = lmts_pkg::clamp_sub(w_bl_s, w_range, w_band.lmax);
                            n_shi = lmts_pkg::clamp_add(w_bl_s, w_range, 8'd0, w_band.lmax);
                            n_cc = w_bc_s; n_cl = n_slo;
                        end else begin
                            n_sfx = w_bl_s;
                            n_slo = lmts_pkg::clamp_sub(w_bc_s, w_range, w_band.cmax);
                            n_shi = lmts_pkg::clamp_add(w_bc_s, w_range, 8'd0, w_band.cmax);
                            n_cl = w_bl_s; n_cc = n_slo;
                        end
                    end
                    w_drive = (n_phase != lmts_pkg::PH_IDLE) && (n_phase != lmts_pkg::PH_FINISH);
                end
            end
            default: ;
        endcase
        if (w_first_row) begin
            n_tri = 4'd0;
            w_absr = w_first;
            w_load = 1'b1;
        end
        w_g = 3'd0; w_k = 4'd0;
        if (w_load) begin
            // group of twelve rows and row within the group
            if (w_absr >= 7'd60) begin
                w_g = 3'd5; w_k = 4'(w_absr - 7'd60);
            end else if (w_absr >= 7'd48) begin
                w_g = 3'd4; w_k = 4'(w_absr - 7'd48);
            end else if (w_absr >= 7'd36) begin
                w_g = 3'd3; w_k = 4'(w_absr - 7'd36);
            end else if (w_absr >= 7'd24) begin
                w_g = 3'd2; w_k = 4'(w_absr - 7'd24);
            end else if (w_absr >= 7'd12) begin
                w_g = 3'd1; w_k = 4'(w_absr - 7'd12);
            end else begin
                w_g = 3'd0; w_k = w_absr[3:0];
            end
        end
        w_grp = lmts_pkg::group_f(w_g);
        if (w_load) begin
            n_shz = w_k[1]; n_sind = w_k[0]; n_slo = 8'd0;
            n_shi = w_grp.high; n_sinc = w_grp.incr;
            case (w_k[3:2])
                2'd0:    n_sfx = w_grp.fx0;
                2'd1:    n_sfx = w_grp.fx1;
                default: n_sfx = w_grp.fx2;
            endcase
            n_chz = w_k[1];
            n_cl = w_k[0] ? 8'd0 : n_sfx;
            n_cc = w_k[0] ? n_sfx : 8'd0;
        end
    end

    always_comb begin
        o_res.drive  = w_drive || w_dbest;
        o_res.l      = w_dbest ? n_bl : (w_drive ? n_cl : 8'd0);
        o_res.c      = w_dbest ? n_bc : (w_drive ? n_cc : 8'd0);
        o_res.z      = w_dbest ? n_bhz : (w_drive && n_chz);
        o_res.rep    = w_rep;
        o_res.ok     = w_rep && w_ok;
        o_res.active = n_active;
        o_res.phase  = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lmts_pkg::PH_IDLE; r_div <= 8'd0; r_quick <= 1'b0; r_active <= 1'b0;
            r_band <= 3'd0; r_tri <= 4'd0; r_shz <= 1'b0; r_sind <= 1'b0;
            r_slo <= 8'd0; r_shi <= 8'd0; r_sinc <= 8'd0; r_sfx <= 8'd0;
            r_cl <= 8'd0; r_cc <= 8'd0; r_chz <= 1'b0;
            r_bl <= 8'd0; r_bc <= 8'd0; r_bhz <= 1'b0; r_bsi <= 1'b0;
            r_bv <= lmts_pkg::VSWR_WORST;
        end else if (i_en) begin
            r_phase <= n_phase; r_div <= n_div; r_quick <= n_quick; r_active <= n_active;
            r_band <= n_band; r_tri <= n_tri; r_shz <= n_shz; r_sind <= n_sind;
            r_slo <= n_slo; r_shi <= n_shi; r_sinc <= n_sinc; r_sfx <= n_sfx;
            r_cl <= n_cl; r_cc <= n_cc; r_chz <= n_chz;
            r_bl <= n_bl; r_bc <= n_bc; r_bhz <= n_bhz; r_bsi <= n_bsi; r_bv <= n_bv;
        end
    end
endmodule

// ===== hw/rtl/lmatch_tuner_search_sequencer.sv =====
// ----------------------------------------------------------------------------
// lmatch_tuner_search_sequencer
// search sequencer of an l-match antenna tuner with apb configuration
// path: a transaction passes the input register (r_item, r_iv), then the result register (r_res, r_ov)
// throughput: one transaction per cycle while i_ready holds, set by the input and result registers
// reset: synchronous active low, clears search state and loads register defaults
// ----------------------------------------------------------------------------
module lmatch_tuner_search_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_vswr,
    input  logic [7:0]  i_hw_inductance,
    input  logic [7:0]  i_hw_capacitance,
    input  logic        i_hw_high_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_drive,
    output logic [7:0]  o_out_inductance,
    output logic [7:0]  o_out_capacitance,
    output logic        o_out_high_z,
    output logic        o_report_valid,
    output logic        o_report_success,
    output logic        o_tuning_active,
    output logic [2:0]  o_phase
);
    lmts_pkg::t_cfg    w_cfg;
    lmts_pkg::t_item   r_item;
    lmts_pkg::t_result w_res, r_res;
    logic              r_iv, r_ov, w_adv, w_oload;

    lmts_cfg_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_cfg(w_cfg)
    );

    assign w_oload = !r_ov || i_ready;
    assign w_adv   = r_iv && w_oload;
    assign o_ready = !r_iv || w_oload;

    lmts_core u_core (
        .i_clk, .i_rst_n, .i_en(w_adv), .i_cfg(w_cfg), .i_item(r_item), .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_ready) r_iv <= i_valid;
            if (w_oload) r_ov <= r_iv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_item <= '{i_func, i_vswr, i_hw_inductance, i_hw_capacitance, i_hw_high_z};
        if (w_adv) r_res <= w_res;
    end

    assign o_valid           = r_ov;
    assign o_drive           = r_res.drive;
    assign o_out_inductance  = r_res.l;
    assign o_out_capacitance = r_res.c;
    assign o_out_high_z      = r_res.z;
    assign o_report_valid    = r_res.rep;
    assign o_report_success  = r_res.ok;
    assign o_tuning_active   = r_res.active;
    assign o_phase           = r_res.phase;
endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the l-match tuner search sequencer against a cycle-free predictor
// of its search: start, cancel and tick transactions are sent through the
// valid/ready input, every result is compared field by field in order, and
// the apb registers are rewritten between phases with random and extreme
// values while sender gaps and receiver stalls vary from phase to phase
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int LIMIT = 400000;

    localparam logic [7:0] BANDS [0:5][0:8] = '{
        '{8'd1, 8'd0, 8'd12, 8'd255, 8'd255, 8'd24, 8'd32, 8'd4, 8'd8},
        '{8'd3, 8'd12, 8'd12, 8'd255, 8'd255, 8'd24, 8'd32, 8'd4, 8'd8},
        '{8'd7, 8'd24, 8'd12, 8'd210, 8'd210, 8'd12, 8'd24, 8'd4, 8'd8},
        '{8'd14, 8'd36, 8'd12, 8'd100, 8'd100, 8'd6, 8'd12, 8'd2, 8'd8},
        '{8'd29, 8'd48, 8'd12, 8'd60, 8'd60, 8'd3, 8'd8, 8'd1, 8'd8},
        '{8'd64, 8'd60, 8'd12, 8'd30, 8'd30, 8'd2, 8'd8, 8'd1, 8'd8}
    };
    localparam logic [7:0] GROUPS [0:5][0:4] = '{
        '{8'd255, 8'd24, 8'd0, 8'd48, 8'd96},
        '{8'd255, 8'd24, 8'd0, 8'd36, 8'd72},
        '{8'd210, 8'd20, 8'd0, 8'd18, 8'd36},
        '{8'd100, 8'd10, 8'd0, 8'd18, 8'd36},
        '{8'd55, 8'd5, 8'd0, 8'd8, 8'd16},
        '{8'd20, 8'd2, 8'd0, 8'd3, 8'd6}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [15:0] i_vswr = '0;
    logic [7:0]  i_hw_inductance = '0, i_hw_capacitance = '0;
    logic        i_hw_high_z = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_drive, o_out_high_z, o_report_valid, o_report_success, o_tuning_active;
    logic [7:0]  o_out_inductance, o_out_capacitance;
    logic [2:0]  o_phase;

    lmatch_tuner_search_sequencer dut (.*);

    always #6 i_clk = ~i_clk;

    // tuner search state mirror
    lmts_pkg::t_cfg cfg;
    logic [2:0] ph, brow;
    logic [7:0] div, slo, shi, sinc, sfix, cur_l, cur_c, best_l, best_c;
    logic [3:0] trow;
    logic       quick, act, swz, swl, cur_z, best_z, best_swl;
    logic [15:0] best_v;

    lmts_pkg::t_result expected_q[$];
    int errors = 0, cycles = 0, results_seen = 0, reports = 0, successes = 0;
    int sent = 0, send_gap_pct = 0, recv_stall_pct = 0;

    function automatic logic [7:0] bnd(input int idx);
        return BANDS[(brow < 6) ? brow : 0][idx];
    endfunction

    function automatic logic [7:0] clip(input int v, input int lo, input int hi);
        if (v < lo) v = lo;
        else if (v > hi) v = hi;
        return v[7:0];
    endfunction

    function automatic void init_cur();
        cur_z = swz;
        if (swl) begin
            cur_c = sfix;
            cur_l = slo;
        end else begin
            cur_l = sfix;
            cur_c = slo;
        end
    endfunction

    function automatic void load_row(input int absr);
        int g, k;
        g = absr / 12;
        k = absr % 12;
        if (g >= 6) g = 5;
        swz = k[1];
        swl = k[0];
        slo = 0;
        shi = GROUPS[g][0];
        sinc = GROUPS[g][1];
        sfix = GROUPS[g][2 + (k >> 2)];
        init_cur();
    endfunction

    function automatic void first_row();
        int absr;
        absr = bnd(1);
        trow = 0;
        if (absr >= lmts_pkg::ROW_LIMIT) absr = lmts_pkg::ROW_LIMIT - 1;
        load_row(absr);
    endfunction

    function automatic logic next_row();
        int absr;
        trow = trow + 4'd1;
        absr = int'(trow) + int'(bnd(1));
        if (trow >= bnd(2) || absr >= lmts_pkg::ROW_LIMIT) return 1'b0;
        load_row(absr);
        return 1'b1;
    endfunction

    function automatic logic next_step();
        if (swl) begin
            if (cur_l == shi) return 1'b0;
            cur_l = clip(int'(cur_l) + int'(sinc), slo, shi);
        end else begin
            if (cur_c == shi) return 1'b0;
            cur_c = clip(int'(cur_c) + int'(sinc), slo, shi);
        end
        return 1'b1;
    endfunction

    function automatic void narrow_sweep(input logic [7:0] inc, input logic [7:0] rng);
        swl = !swl;
        sinc = inc;
        if (swl) begin
            sfix = best_c;
            slo = clip(int'(best_l) - int'(rng), 0, bnd(3));
            shi = clip(int'(best_l) + int'(rng), 0, bnd(3));
        end else begin
            sfix = best_l;
            slo = clip(int'(best_c) - int'(rng), 0, bnd(4));
            shi = clip(int'(best_c) + int'(rng), 0, bnd(4));
        end
        init_cur();
    endfunction

    function automatic void search_reset();
        cfg = '{8'd0, 1'b0, 8'd2, 8'd20};
        ph = lmts_pkg::PH_IDLE; div = 0; brow = 0; trow = 0; quick = 0; act = 0;
        swz = 0; swl = 0; slo = 0; shi = 0; sinc = 0; sfix = 0;
        cur_l = 0; cur_c = 0; cur_z = 0; best_l = 0; best_c = 0; best_z = 0;
        best_swl = 0; best_v = lmts_pkg::VSWR_WORST;
    endfunction

    function automatic void predict_search(input lmts_pkg::t_item it);
        logic drv, drv_best, rep, ok, more;
        lmts_pkg::t_result r;
        drv = 0; drv_best = 0; rep = 0; ok = 0; more = 0;
        if (it.func == lmts_pkg::FUNC_START) begin
            brow = 0;
            for (int b = lmts_pkg::BAND_COUNT; b > 0; b--)
                if (cfg.freq_mhz <= BANDS[b - 1][0]) brow = 3'(b - 1);
            if (cfg.quick_tune_enable) begin
                quick = 1; ph = lmts_pkg::PH_FINE1; swz = it.hw_z; swl = 1; sinc = 1;
                sfix = it.hw_c;
                slo = clip(int'(it.hw_l) - int'(bnd(8)), 0, bnd(3));
                shi = clip(int'(it.hw_l) + int'(bnd(8)), 0, bnd(3));
                init_cur();
            end else begin
                quick = 0; ph = lmts_pkg::PH_COARSE1;
                first_row();
            end
            div = cfg.start_delay_ticks;
            act = 1;
            best_v = lmts_pkg::VSWR_WORST;
            drv = 1;
        end else if (it.func == lmts_pkg::FUNC_CANCEL) begin
            act = 0;
            ph = lmts_pkg::PH_IDLE;
        end else if (it.func == lmts_pkg::FUNC_TICK) begin
            if (div > 1) begin
                div = div - 8'd1;
            end else begin
                div = cfg.ticks_per_step;
                if (!act) ph = lmts_pkg::PH_IDLE;
                if (ph != lmts_pkg::PH_IDLE && ph != lmts_pkg::PH_FINISH) begin
                    if (it.vswr < best_v) begin
                        best_v = it.vswr; best_l = cur_l; best_c = cur_c;
                        best_z = cur_z; best_swl = swl;
                    end
                    more = next_step();
                end
                case (ph)
                    lmts_pkg::PH_COARSE1: begin
                        if (!more && !next_row()) begin
                            ph = lmts_pkg::PH_COARSE2; swz = best_z; swl = !best_swl;
                            sinc = bnd(5); slo = 0;
                            if (swl) begin
                                shi = bnd(3); sfix = best_c;
                            end else begin
                                shi = bnd(4); sfix = best_l;
                            end
                            init_cur();
                        end
                    end
                    lmts_pkg::PH_COARSE2: if (!more) begin
                        ph = lmts_pkg::PH_MID1; narrow_sweep(bnd(7), bnd(6));
                    end
                    lmts_pkg::PH_MID1: if (!more) begin
                        ph = lmts_pkg::PH_MID2; narrow_sweep(bnd(7), bnd(6));
                    end
                    lmts_pkg::PH_MID2: if (!more) begin
                        ph = lmts_pkg::PH_FINE1; narrow_sweep(8'd1, bnd(8));
                    end
                    lmts_pkg::PH_FINE1: if (!more) begin
                        ph = lmts_pkg::PH_FINE2; narrow_sweep(8'd1, bnd(8));
                    end
                    lmts_pkg::PH_FINE2: if (!more) begin
                        if (!quick || best_v < lmts_pkg::THR_QUICK) begin
                            ok = best_v < (quick ? lmts_pkg::THR_QUICK : lmts_pkg::THR_FULL);
                            quick = 0; ph = lmts_pkg::PH_FINISH; drv_best = 1; rep = 1;
                        end else begin
                            quick = 0; best_v = lmts_pkg::VSWR_WORST;
                            ph = lmts_pkg::PH_COARSE1;
                            first_row();
                        end
                    end
                    lmts_pkg::PH_FINISH: begin
                        ph = lmts_pkg::PH_IDLE; act = 0;
                    end
                    default: ;
                endcase
                if (ph != lmts_pkg::PH_IDLE && ph != lmts_pkg::PH_FINISH) drv = 1;
            end
        end
        r.drive = drv | drv_best;
        r.l = drv_best ? best_l : (drv ? cur_l : 8'd0);
        r.c = drv_best ? best_c : (drv ? cur_c : 8'd0);
        r.z = drv_best ? best_z : (drv & cur_z);
        r.rep = rep;
        r.ok = rep & ok;
        r.active = act;
        r.phase = ph;
        expected_q.push_back(r);
    endfunction

    task automatic send(input logic [1:0] f, input logic [15:0] v, input logic [7:0] l,
                        input logic [7:0] c, input logic z);
        lmts_pkg::t_item it;
        it = '{f, v, l, c, z};
        i_valid <= 1'b1;
        i_func <= f; i_vswr <= v;
        i_hw_inductance <= l; i_hw_capacitance <= c; i_hw_high_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_search(it);
        sent++;
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic tick(input logic [15:0] v);
        send(lmts_pkg::FUNC_TICK, v, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            lmts_pkg::REG_FREQ:  cfg.freq_mhz = val;
            lmts_pkg::REG_QUICK: cfg.quick_tune_enable = val[0];
            lmts_pkg::REG_TPS:   cfg.ticks_per_step = val;
            default:             cfg.start_delay_ticks = val;
        endcase
    endtask

    task automatic set_cfg(input logic [7:0] f, input logic q, input logic [7:0] tps,
                           input logic [7:0] dly);
        write_reg(lmts_pkg::REG_FREQ, f);
        write_reg(lmts_pkg::REG_QUICK, {7'd0, q});
        write_reg(lmts_pkg::REG_TPS, tps);
        write_reg(lmts_pkg::REG_DELAY, dly);
    endtask

    // vswr mostly in the useful range, sometimes a good match, sometimes anything
    function automatic logic [15:0] rand_vswr();
        int k;
        k = $urandom_range(99);
        if (k < 10) return 16'($urandom);
        if (k < 30) return 16'($urandom_range(140, 100));
        return 16'($urandom_range(600, 110));
    endfunction

    // start, then ticks with occasional other kinds until the search is no longer active or max_ticks run out
    task automatic run_tune(input int max_ticks, input int noise_pct);
        int n;
        send(lmts_pkg::FUNC_START, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        n = 0;
        while (act && n < max_ticks) begin
            if ($urandom_range(999) < noise_pct)
                send(2'($urandom_range(3, 1)), 16'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom));
            else
                tick(rand_vswr());
            n++;
        end
    endtask

    always @(posedge i_clk) begin
        lmts_pkg::t_result e;
        if (o_valid && i_ready) begin
            results_seen++;
            if (o_report_valid) reports++;
            if (o_report_success) successes++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected transaction: drive %0b l %0d c %0d phase %0d",
                         $time, o_drive, o_out_inductance, o_out_capacitance, o_phase);
            end else begin
                e = expected_q.pop_front();
                if (e.drive !== o_drive || e.l !== o_out_inductance
                    || e.c !== o_out_capacitance || e.z !== o_out_high_z
                    || e.rep !== o_report_valid || e.ok !== o_report_success
                    || e.active !== o_tuning_active || e.phase !== o_phase) begin
                    errors++;
                    $display("%0t mismatch exp drive %0b l %0d c %0d z %0b",
                             $time, e.drive, e.l, e.c, e.z);
                    $display("%0t          exp rep %0b ok %0b act %0b ph %0d",
                             $time, e.rep, e.ok, e.active, e.phase);
                    $display("%0t          got drive %0b l %0d c %0d z %0b",
                             $time, o_drive, o_out_inductance, o_out_capacitance,
                             o_out_high_z);
                    $display("%0t          got rep %0b ok %0b act %0b ph %0d",
                             $time, o_report_valid, o_report_success,
                             o_tuning_active, o_phase);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic test_defaults();
        send(lmts_pkg::FUNC_START, 16'd0, 8'd0, 8'd0, 1'b0);
        repeat (30) tick(16'd300);
        send(lmts_pkg::FUNC_CANCEL, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_special_cases();
        // ignored kind, idle ticks, start while tuning, band above every row
        send(FUNC_NONE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
        tick(16'hFFFF);
        set_cfg(8'd255, 1'b0, 8'd0, 8'd1);
        send(lmts_pkg::FUNC_START, 16'd0, 8'd255, 8'd255, 1'b1);
        tick(16'd0);
        tick(16'hFFFF);
        send(lmts_pkg::FUNC_START, 16'd5, 8'd1, 8'd2, 1'b0);
        send(FUNC_NONE, 16'd0, 8'd0, 8'd0, 1'b0);
        tick(16'd200);
        send(lmts_pkg::FUNC_CANCEL, 16'd0, 8'd0, 8'd0, 1'b0);
        tick(16'd100);
        set_cfg(8'd64, 1'b1, 8'd255, 8'd255);
        send(lmts_pkg::FUNC_START, 16'd0, 8'd0, 8'd255, 1'b1);
        repeat (4) tick(16'd0);
        send(lmts_pkg::FUNC_CANCEL, 16'd0, 8'd0, 8'd0, 1'b0);
    endtask

    task automatic test_quick_tune();
        // a quick tune that matches, then one that falls into a full tune
        set_cfg(8'd3, 1'b1, 8'd1, 8'd1);
        send(lmts_pkg::FUNC_START, 16'd0, 8'd250, 8'd17, 1'b1);
        while (act) tick(16'd100);
        write_reg(lmts_pkg::REG_FREQ, 8'd64);
        send(lmts_pkg::FUNC_START, 16'd0, 8'd4, 8'd99, 1'b0);
        while (act) tick(16'd400);
    endtask

    task automatic test_random();
        int target;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 51; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 51; end
                default: begin send_gap_pct = 15; recv_stall_pct = 15; end
            endcase
            set_cfg(8'($urandom), 1'($urandom), 8'($urandom_range(2, 1)),
                    8'($urandom_range(3, 1)));
            target = sent + 60;
            while (sent < target) begin
                if ($urandom_range(99) < 80) begin
                    if (!cfg.quick_tune_enable || $urandom_range(3) == 0)
                        write_reg(lmts_pkg::REG_FREQ, 8'($urandom_range(64, 15)));
                    run_tune(60, 8);
                end else begin
                    repeat ($urandom_range(6, 1))
                        send(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                             1'($urandom));
                end
            end
        end
    endtask

    initial begin
        search_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_special_cases();
        test_quick_tune();
        test_random();
        drain();
        repeat (10) @(posedge i_clk);
        $display("tb: %0d transactions sent, %0d results checked", sent, results_seen);
        $display("tb: %0d tunes reported, %0d of them matched", reports, successes);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
